// ===== hdl/hrpi_pkg.sv =====
package hrpi_pkg;

    localparam int KEY_W = 64;
    localparam int POS_W = 32;

    localparam int INDEX_BITS_DEF = 10;
    localparam int RING_SIZE_DEF  = 8;

    // Mixing hash: xor-shift, multiply, xor-shift, multiply, xor-shift.
    localparam logic [KEY_W-1:0] HASH_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_W-1:0] HASH_C2 = 64'h94d049bb133111eb;
    localparam int MIX_SHIFT_A = 30;
    localparam int MIX_SHIFT_B = 27;
    localparam int MIX_SHIFT_C = 31;

    // Which 32x32 partial product the shared multiplier forms.
    typedef enum logic [1:0] {
        MP_NONE = 2'd0,
        MP_LL   = 2'd1,
        MP_LH   = 2'd2,
        MP_HL   = 2'd3
    } mul_part_t;

    typedef enum logic [1:0] {
        ACC_NONE   = 2'd0,
        ACC_LOAD   = 2'd1,
        ACC_ADD_HI = 2'd2
    } acc_op_t;

    typedef struct packed {
        logic      load_in;
        mul_part_t mul_part;
        logic      const_sel;
        acc_op_t   acc_op;
        logic      mix;
        logic      slot_load;
        logic      meta_rd;
        logic      insert_wr;
        logic      clear_step;
        logic      lookup_start;
        logic      pos_read;
        logic      out_load_pos;
        logic      out_load_miss;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic req_lookup;
        logic slot_hit;
        logic last_pos;
        logic out_free;
    } stat_t;

endpackage

// ===== hdl/hrpi_ram.sv =====
module hrpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/hrpi_dp.sv =====
module hrpi_dp #(
    parameter int INDEX_BITS = hrpi_pkg::INDEX_BITS_DEF,
    parameter int RING_SIZE  = hrpi_pkg::RING_SIZE_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hrpi_pkg::cmd_t           cmd,
    output hrpi_pkg::stat_t          stat,
    input  logic                     req_type,
    input  logic [hrpi_pkg::KEY_W-1:0] key,
    input  logic [hrpi_pkg::POS_W-1:0] position,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic                     hit,
    output logic [hrpi_pkg::POS_W-1:0] found_position,
    output logic                     last
);

    import hrpi_pkg::*;

    localparam int RING_BITS = $clog2(RING_SIZE);
    localparam int CNT_W     = $clog2(RING_SIZE + 1);
    localparam int META_W    = KEY_W + CNT_W + RING_BITS;
    localparam int SLOTS     = 1 << INDEX_BITS;
    localparam int POS_DEPTH = 1 << (INDEX_BITS + RING_BITS);
    localparam logic [RING_BITS-1:0] HEAD_MAX = RING_BITS'(RING_SIZE - 1);
    localparam logic [CNT_W-1:0]     CNT_MAX  = CNT_W'(RING_SIZE);

    logic                  req_lookup_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [KEY_W-1:0]      v_reg;
    logic [KEY_W-1:0]      prod_reg;
    logic [KEY_W-1:0]      acc_reg;
    logic [INDEX_BITS-1:0] slot_reg;
    logic [INDEX_BITS-1:0] clr_addr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [RING_BITS-1:0]  idx_reg;
    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [POS_W-1:0]      out_pos_reg;
    logic                  out_last_reg;

    logic [KEY_W-1:0]      key_eff;
    logic [KEY_W-1:0]      hash_const;
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [KEY_W-1:0]      prod;
    logic [INDEX_BITS-1:0] hash_fin;

    logic [META_W-1:0]     meta_q;
    logic [KEY_W-1:0]      tag_q;
    logic [CNT_W-1:0]      cnt_q;
    logic [RING_BITS-1:0]  head_q;
    logic                  tag_match;
    logic [RING_BITS-1:0]  head_eff;
    logic [CNT_W-1:0]      cnt_eff;
    logic [RING_BITS-1:0]  head_new;
    logic [CNT_W-1:0]      cnt_new;
    logic [RING_BITS-1:0]  head_prev;
    logic [RING_BITS-1:0]  idx_prev;

    logic                  meta_we;
    logic [INDEX_BITS-1:0] meta_waddr;
    logic [META_W-1:0]     meta_wdata;
    logic [POS_W-1:0]      pos_q;

    // A key of zero is stored as one so that a zero tag always means empty.
    assign key_eff = (key == '0) ? KEY_W'(1) : key;

    assign hash_const = cmd.const_sel ? HASH_C2 : HASH_C1;
    assign mul_a      = (cmd.mul_part == MP_HL) ? v_reg[63:32] : v_reg[31:0];
    assign mul_b      = (cmd.mul_part == MP_LH) ? hash_const[63:32] : hash_const[31:0];
    assign prod       = {32'b0, mul_a} * {32'b0, mul_b};
    // Only the slot bits of the final xor-shift are needed.
    assign hash_fin   = acc_reg[INDEX_BITS-1:0] ^ acc_reg[MIX_SHIFT_C +: INDEX_BITS];

    assign {tag_q, cnt_q, head_q} = meta_q;
    assign tag_match = (tag_q == key_reg);
    assign head_eff  = tag_match ? head_q : '0;
    assign cnt_eff   = tag_match ? cnt_q : '0;
    assign head_new  = (head_eff == HEAD_MAX) ? '0 : head_eff + RING_BITS'(1);
    assign cnt_new   = (cnt_eff >= CNT_MAX) ? CNT_MAX : cnt_eff + CNT_W'(1);
    assign head_prev = (head_q == '0) ? HEAD_MAX : head_q - RING_BITS'(1);
    assign idx_prev  = (idx_reg == '0) ? HEAD_MAX : idx_reg - RING_BITS'(1);

    assign meta_we    = cmd.clear_step | cmd.insert_wr;
    assign meta_waddr = cmd.clear_step ? clr_addr_reg : slot_reg;
    assign meta_wdata = cmd.clear_step ? '0 : {key_reg, cnt_new, head_new};

    hrpi_ram #(
        .WIDTH (META_W),
        .DEPTH (SLOTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (cmd.meta_rd),
        .raddr (slot_reg),
        .rdata (meta_q)
    );

    hrpi_ram #(
        .WIDTH (POS_W),
        .DEPTH (POS_DEPTH)
    ) u_pos_ram (
        .clk   (clk),
        .we    (cmd.insert_wr),
        .waddr ({slot_reg, head_eff}),
        .wdata (pos_reg),
        .re    (cmd.pos_read),
        .raddr ({slot_reg, idx_reg}),
        .rdata (pos_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + INDEX_BITS'(1);
            end
            if (cmd.lookup_start)
            begin
                cnt_reg <= (cnt_q > CNT_MAX) ? CNT_MAX : cnt_q;
                idx_reg <= head_prev;
            end
            else
            begin
                if (cmd.pos_read)
                begin
                    idx_reg <= idx_prev;
                end
                if (cmd.out_load_pos)
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
            if (cmd.out_load_pos || cmd.out_load_miss)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_lookup_reg <= req_type;
            key_reg        <= key_eff;
            pos_reg        <= position;
            v_reg          <= key_eff ^ (key_eff >> MIX_SHIFT_A);
        end
        else if (cmd.mix)
        begin
            v_reg <= acc_reg ^ (acc_reg >> MIX_SHIFT_B);
        end
        if (cmd.mul_part != MP_NONE)
        begin
            prod_reg <= prod;
        end
        case (cmd.acc_op)
            ACC_LOAD:   acc_reg <= prod_reg;
            ACC_ADD_HI: acc_reg <= acc_reg + {prod_reg[31:0], 32'b0};
            default:    acc_reg <= acc_reg;
        endcase
        if (cmd.slot_load)
        begin
            slot_reg <= hash_fin;
        end
        if (cmd.out_load_pos)
        begin
            out_hit_reg  <= 1'b1;
            out_pos_reg  <= pos_q;
            out_last_reg <= (cnt_reg == CNT_W'(1));
        end
        else if (cmd.out_load_miss)
        begin
            out_hit_reg  <= 1'b0;
            out_pos_reg  <= '0;
            out_last_reg <= 1'b1;
        end
    end

    assign stat.clear_done = (clr_addr_reg == INDEX_BITS'(SLOTS - 1));
    assign stat.req_lookup = req_lookup_reg;
    assign stat.slot_hit   = tag_match && (cnt_q != '0);
    assign stat.last_pos   = (cnt_reg == CNT_W'(1));
    assign stat.out_free   = !out_valid_reg || !rsp_stall;

    assign rsp_valid      = out_valid_reg;
    assign hit            = out_hit_reg;
    assign found_position = out_pos_reg;
    assign last           = out_last_reg;

endmodule

// ===== hdl/hrpi_ctrl.sv =====
module hrpi_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  hrpi_pkg::stat_t stat,
    output hrpi_pkg::cmd_t  cmd
);

    import hrpi_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_H1_LL,
        S_H1_LH,
        S_H1_HL,
        S_H1_ACC,
        S_MIX,
        S_H2_LL,
        S_H2_LH,
        S_H2_HL,
        S_H2_ACC,
        S_SLOT,
        S_RD_META,
        S_DECIDE,
        S_MISS,
        S_POS,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_H1_LL;
                end
            end
            S_H1_LL:
            begin
                cmd.mul_part = MP_LL;
                state_next   = S_H1_LH;
            end
            S_H1_LH:
            begin
                cmd.mul_part = MP_LH;
                cmd.acc_op   = ACC_LOAD;
                state_next   = S_H1_HL;
            end
            S_H1_HL:
            begin
                cmd.mul_part = MP_HL;
                cmd.acc_op   = ACC_ADD_HI;
                state_next   = S_H1_ACC;
            end
            S_H1_ACC:
            begin
                cmd.acc_op = ACC_ADD_HI;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_H2_LL;
            end
            S_H2_LL:
            begin
                cmd.mul_part  = MP_LL;
                cmd.const_sel = 1'b1;
                state_next    = S_H2_LH;
            end
            S_H2_LH:
            begin
                cmd.mul_part  = MP_LH;
                cmd.const_sel = 1'b1;
                cmd.acc_op    = ACC_LOAD;
                state_next    = S_H2_HL;
            end
            S_H2_HL:
            begin
                cmd.mul_part  = MP_HL;
                cmd.const_sel = 1'b1;
                cmd.acc_op    = ACC_ADD_HI;
                state_next    = S_H2_ACC;
            end
            S_H2_ACC:
            begin
                cmd.acc_op = ACC_ADD_HI;
                state_next = S_SLOT;
            end
            S_SLOT:
            begin
                cmd.slot_load = 1'b1;
                state_next    = S_RD_META;
            end
            S_RD_META:
            begin
                cmd.meta_rd = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!stat.req_lookup)
                begin
                    cmd.insert_wr = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.slot_hit)
                begin
                    cmd.lookup_start = 1'b1;
                    state_next       = S_POS;
                end
                else
                begin
                    state_next = S_MISS;
                end
            end
            S_MISS:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load_miss = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_POS:
            begin
                cmd.pos_read = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                // The RAM holds its read data until the next read, so a stalled
                // result simply waits here.
                if (stat.out_free)
                begin
                    cmd.out_load_pos = 1'b1;
                    if (stat.last_pos)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.pos_read = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/hashed_recent_position_index_unit.sv =====
// Channel   Handshake              Payload
// request   req_valid / req_stall  req_type, key, position
// response  rsp_valid / rsp_stall  hit, found_position, last
//
// Each request is hashed on one shared 32x32 multiplier and the slot metadata RAM
// is read, then a decision state follows: an insert ends there, a miss waits to
// post its result, and a hit returns each stored position in turn, newest first.
// After reset the slot metadata RAM is cleared one slot per cycle, all
// 2**INDEX_BITS slots, with req_stall held high.
// A stalled response holds in the output register; the block waits at its next result.
module hashed_recent_position_index_unit #(
    parameter int INDEX_BITS = hrpi_pkg::INDEX_BITS_DEF,
    parameter int RING_SIZE  = hrpi_pkg::RING_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic                       req_type,
    input  logic [hrpi_pkg::KEY_W-1:0] key,
    input  logic [hrpi_pkg::POS_W-1:0] position,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic                       hit,
    output logic [hrpi_pkg::POS_W-1:0] found_position,
    output logic                       last
);

    import hrpi_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    hrpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    hrpi_dp #(
        .INDEX_BITS (INDEX_BITS),
        .RING_SIZE  (RING_SIZE)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .key            (key),
        .position       (position),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .hit            (hit),
        .found_position (found_position),
        .last           (last)
    );

endmodule

// ===== hdl/hrpi_checker.sv =====
module hrpi_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_stall,
    input logic                       req_type,
    input logic [hrpi_pkg::KEY_W-1:0] key,
    input logic [hrpi_pkg::POS_W-1:0] position,
    input logic                       rsp_valid,
    input logic                       rsp_stall,
    input logic                       hit,
    input logic [hrpi_pkg::POS_W-1:0] found_position,
    input logic                       last
);

    // A stalled response transaction stays offered with the same payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(hit) && $stable(last)
            && $stable(found_position))
    else $error("stalled response changed");

    // A miss is a single result carrying a zero position.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> last && (found_position == '0))
    else $error("miss response is not a final zero result");

    // Hashing runs through a sequence of states, so an accepted request always busies the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("request accepted on back-to-back cycles");

endmodule

bind hashed_recent_position_index_unit hrpi_checker u_hrpi_checker (.*);

// ===== test/tb_hashed_recent_position_index_unit.sv =====
module tb_hashed_recent_position_index_unit;
    import hrpi_pkg::*;

    localparam int IDX_W = INDEX_BITS_DEF;
    localparam int RING  = RING_SIZE_DEF;
    localparam int SLOTS = 1 << IDX_W;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
    localparam logic [POS_W-1:0] POS_ONES = {POS_W{1'b1}};

    localparam int POOL_N        = 12;
    localparam int RAND_ITEMS    = 330;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 40;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
        logic             last;
    } recall_t;

    typedef struct {
        logic             rtype;
        logic [KEY_W-1:0] k;
        logic [POS_W-1:0] p;
        bit               typed;
        recall_t          want;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    logic             req_type;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
    logic             rsp_valid;
    logic             rsp_stall;
    logic             hit;
    logic [POS_W-1:0] found_position;
    logic             last;

    // Shadow copy of the slot store used to predict lookups.
    logic [KEY_W-1:0] tag_mem  [SLOTS];
    logic [POS_W-1:0] ring_mem [SLOTS][RING];
    int unsigned      cnt_mem  [SLOTS];
    int unsigned      head_mem [SLOTS];

    recall_t  recall_queue [$];
    dir_row_t dir_rows [$];
    int       fail_count = 0;
    int       rsp_taken  = 0;
    bit       req_free   = 1'b0;

    hashed_recent_position_index_unit #(
        .INDEX_BITS(IDX_W),
        .RING_SIZE (RING)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .key           (key),
        .position      (position),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .hit           (hit),
        .found_position(found_position),
        .last          (last)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        foreach (tag_mem[s])
        begin
            tag_mem[s]  = '0;
            cnt_mem[s]  = 0;
            head_mem[s] = 0;
        end
    end

    function automatic logic [IDX_W-1:0] slot_of_key(input logic [KEY_W-1:0] k_raw);
        logic [KEY_W-1:0] v;
        v = (k_raw == '0) ? 64'd1 : k_raw;
        v = v ^ (v >> MIX_SHIFT_A);
        v = v * HASH_C1;
        v = v ^ (v >> MIX_SHIFT_B);
        v = v * HASH_C2;
        v = v ^ (v >> MIX_SHIFT_C);
        return v[IDX_W-1:0];
    endfunction

    // Updates the shadow store and queues the recalled positions of a lookup.
    function automatic void predict_recall(input logic rtype, input logic [KEY_W-1:0] k_raw,
                                           input logic [POS_W-1:0] p);
        logic [KEY_W-1:0] k;
        logic [IDX_W-1:0] s;
        int unsigned      n;
        int unsigned      idx;
        recall_t          r;
        k = (k_raw == '0) ? 64'd1 : k_raw;
        s = slot_of_key(k);
        if (rtype == REQ_INSERT)
        begin
            if (tag_mem[s] != k)
            begin
                tag_mem[s]  = k;
                cnt_mem[s]  = 0;
                head_mem[s] = 0;
            end
            ring_mem[s][head_mem[s]] = p;
            head_mem[s] = (head_mem[s] + 1) % RING;
            if (cnt_mem[s] < RING)
                cnt_mem[s] = cnt_mem[s] + 1;
        end
        else if (tag_mem[s] != k || cnt_mem[s] == 0)
        begin
            r.hit  = 1'b0;
            r.pos  = '0;
            r.last = 1'b1;
            recall_queue = {recall_queue, r};
        end
        else
        begin
            n = cnt_mem[s];
            for (int i = 0; i < n; i++)
            begin
                idx    = (head_mem[s] + 2 * RING - 1 - i) % RING;
                r.hit  = 1'b1;
                r.pos  = ring_mem[s][idx];
                r.last = (i + 1 == n);
                recall_queue = {recall_queue, r};
            end
        end
    endfunction

    task automatic add_row(input logic rtype, input logic [KEY_W-1:0] k,
                           input logic [POS_W-1:0] p, input bit typed,
                           input logic w_hit, input logic [POS_W-1:0] w_pos,
                           input logic w_last);
        dir_row_t row;
        row.rtype     = rtype;
        row.k         = k;
        row.p         = p;
        row.typed     = typed;
        row.want.hit  = w_hit;
        row.want.pos  = w_pos;
        row.want.last = w_last;
        dir_rows = {dir_rows, row};
    endtask

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_req(input logic rtype, input logic [KEY_W-1:0] k,
                            input logic [POS_W-1:0] p, input bit typed, input recall_t want);
        while (!req_free && $urandom_range(99) < 29)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= rtype;
        key       <= k;
        position  <= p;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (typed)
            recall_queue = {recall_queue, want};
        else
            predict_recall(rtype, k, p);
    endtask

    initial
    begin
        logic [KEY_W-1:0] k_coll;
        logic [KEY_W-1:0] k_seq;
        logic [KEY_W-1:0] k_pick;
        logic [KEY_W-1:0] pool [POOL_N];
        logic [POS_W-1:0] p;
        recall_t          no_want;
        int unsigned      r;

        no_want   = '0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_type  <= REQ_INSERT;
        key       <= '0;
        position  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // A key that lands in the same slot as the all-ones key, for a takeover.
        k_coll = 64'd2;
        while (slot_of_key(k_coll) != slot_of_key(KEY_ONES))
            k_coll = k_coll + 1;
        k_seq = 64'h0123_4567_89ab_cdef;

        add_row(REQ_LOOKUP, '0,       '0,           1, 1'b0, '0,           1'b1);
        add_row(REQ_LOOKUP, KEY_ONES, POS_ONES,     1, 1'b0, '0,           1'b1);
        add_row(REQ_INSERT, '0,       '0,           0, 1'b0, '0,           1'b0);
        add_row(REQ_LOOKUP, 64'd1,    POS_ONES,     1, 1'b1, '0,           1'b1);
        add_row(REQ_LOOKUP, '0,       '0,           1, 1'b1, '0,           1'b1);
        add_row(REQ_INSERT, KEY_ONES, POS_ONES,     0, 1'b0, '0,           1'b0);
        add_row(REQ_LOOKUP, KEY_ONES, '0,           1, 1'b1, POS_ONES,     1'b1);
        add_row(REQ_INSERT, k_coll,   32'h5a5a5a5a, 0, 1'b0, '0,           1'b0);
        add_row(REQ_LOOKUP, KEY_ONES, '0,           1, 1'b0, '0,           1'b1);
        add_row(REQ_LOOKUP, k_coll,   '0,           1, 1'b1, 32'h5a5a5a5a, 1'b1);
        // Ten inserts under one key: the ring wraps and the count saturates.
        for (int i = 1; i <= 10; i++)
            add_row(REQ_INSERT, k_seq, POS_W'(i), 0, 1'b0, '0, 1'b0);
        add_row(REQ_LOOKUP, k_seq,    '0,           0, 1'b0, '0,           1'b0);
        add_row(REQ_INSERT, 64'd1,    32'h80000000, 0, 1'b0, '0,           1'b0);
        add_row(REQ_LOOKUP, '0,       '0,           0, 1'b0, '0,           1'b0);

        foreach (dir_rows[i])
            send_req(dir_rows[i].rtype, dir_rows[i].k, dir_rows[i].p,
                     dir_rows[i].typed, dir_rows[i].want);

        // Key pool: zero, all ones, random keys and partners that share a slot.
        pool[0] = '0;
        pool[1] = KEY_ONES;
        for (int i = 2; i < 8; i++)
            pool[i] = {$urandom, $urandom};
        for (int i = 8; i < POOL_N; i++)
        begin
            k_pick = {$urandom, $urandom};
            while (slot_of_key(k_pick) != slot_of_key(pool[i - 8]) || k_pick <= 64'd1)
                k_pick = {$urandom, $urandom};
            pool[i] = k_pick;
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            req_free = (n >= 60 && n < 140);
            if (n == RAND_ITEMS / 2)
            begin
                req_valid <= 1'b0;
                do
                    @(posedge clk);
                while (recall_queue.size() != 0);
            end
            case ($urandom_range(15))
                0:       p = '0;
                1:       p = POS_ONES;
                default: p = $urandom;
            endcase
            r = $urandom_range(99);
            if (r < 50)
                send_req(REQ_INSERT, pool[$urandom_range(POOL_N - 1)], p, 0, no_want);
            else if (r < 85)
                send_req(REQ_LOOKUP, pool[$urandom_range(POOL_N - 1)], p, 0, no_want);
            else if (r < 92)
                send_req(REQ_INSERT, {$urandom, $urandom}, p, 0, no_want);
            else
                send_req(REQ_LOOKUP, {$urandom, $urandom}, p, 0, no_want);
        end
        req_valid <= 1'b0;

        while (recall_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Response side: checks each transaction and applies random stalls, one long stall and a stall-free stretch.
    initial
    begin
        int      hold_left;
        bit      held_once;
        recall_t got;
        recall_t want;

        hold_left = 0;
        held_once = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                got.hit  = hit;
                got.pos  = found_position;
                got.last = last;
                rsp_taken++;
                if (recall_queue.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("unexpected response: hit=%0d pos=%h last=%0d",
                                 got.hit, got.pos, got.last);
                    fail_count++;
                end
                else
                begin
                    want = recall_queue.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < REPORT_MAX)
                            $display("mismatch: expected hit=%0d pos=%h last=%0d",
                                     want.hit, want.pos, want.last,
                                     ", got hit=%0d pos=%h last=%0d",
                                     got.hit, got.pos, got.last);
                        fail_count++;
                    end
                end
            end
            if (!held_once && rsp_taken == HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                held_once = 1'b1;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (rsp_taken >= 120 && rsp_taken < 260)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(99) < 29);
        end
    end

    initial
    begin
        #1000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/hrpi_pkg.sv
hdl/hrpi_ram.sv
hdl/hrpi_dp.sv
hdl/hrpi_ctrl.sv
hdl/hashed_recent_position_index_unit.sv
hdl/hrpi_checker.sv
test/tb_hashed_recent_position_index_unit.sv
